/* hdl/rtxs_pkg.sv */
package rtxs_pkg;

  // sequencer phases
  localparam logic [2:0] PH_RX       = 3'd0;
  localparam logic [2:0] PH_PRE_TX   = 3'd1;
  localparam logic [2:0] PH_TX_ACK   = 3'd2;
  localparam logic [2:0] PH_RELAY    = 3'd3;
  localparam logic [2:0] PH_TX       = 3'd4;
  localparam logic [2:0] PH_BEEP     = 3'd5;
  localparam logic [2:0] PH_TX_TO_RX = 3'd6;
  localparam logic [2:0] PH_RX_ACK   = 3'd7;

  // gate indexes
  localparam logic [1:0] GATE_RX       = 2'd0;
  localparam logic [1:0] GATE_TRANS    = 2'd1;
  localparam logic [1:0] GATE_TX_UP    = 2'd2;
  localparam logic [1:0] GATE_TX_DOWN  = 2'd3;

  // register indexes
  localparam logic [2:0] REG_PRE_TX    = 3'd0;
  localparam logic [2:0] REG_RX_TO_TX  = 3'd1;
  localparam logic [2:0] REG_TX_TO_RX  = 3'd2;
  localparam logic [2:0] REG_BREAKIN   = 3'd3;
  localparam logic [2:0] REG_VOX_HOLD  = 3'd4;
  localparam logic [2:0] REG_VOX_GAIN  = 3'd5;
  localparam logic [2:0] REG_AVOX_GAIN = 3'd6;
  localparam logic [2:0] REG_MODE      = 3'd7;

  // register reset values
  localparam logic [7:0] PRE_TX_RST    = 8'd3;
  localparam logic [7:0] RX_TO_TX_RST  = 8'd3;
  localparam logic [7:0] TX_TO_RX_RST  = 8'd3;
  localparam logic [9:0] BREAKIN_RST   = 10'd50;
  localparam logic [9:0] VOX_HOLD_RST  = 10'd200;

  // prefill after reset: (pre_tx + rx_to_tx) * 2
  localparam int RST_FILL = (3 + 3) * 2;

  // vox compare: level * gain / 100, margin 16
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;
  localparam logic [9:0]  VOX_MARGIN   = 10'd16;

  // mode flag bits
  localparam int MODE_CW      = 0;
  localparam int MODE_VOX     = 1;
  localparam int MODE_BREAKIN = 2;
  localparam int MODE_ROGER   = 3;
  localparam int MODE_SIDE    = 4;

  typedef struct packed {
    logic step;
    logic push_bit;
    logic prefill;
  } dly_ctl_t;

endpackage

/* hdl/rtxs_delay_line.sv */
module rtxs_delay_line #(
  parameter int DELAY_DEPTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rtxs_pkg::dly_ctl_t             ctl,
  input  logic [$clog2(DELAY_DEPTH)-1:0] prefill_len,
  output logic                           pop_bit
);

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam logic [AW:0]   CAP      = (AW+1)'(DELAY_DEPTH - 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DELAY_DEPTH - 1);

  logic          mem [DELAY_DEPTH];
  logic [AW-1:0] zero_cnt_r, zero_cnt_nxt;
  logic [AW-1:0] mem_cnt_r, mem_cnt_nxt;
  logic [AW-1:0] wr_r, wr_nxt;
  logic [AW-1:0] rd_r, rd_nxt;
  logic          head_r;
  logic          full;
  logic          push_en;
  logic [AW-1:0] wr_inc;
  logic [AW-1:0] rd_inc;

  assign full    = ({1'b0, zero_cnt_r} + {1'b0, mem_cnt_r}) == CAP;
  assign push_en = ctl.step & ~full;
  assign wr_inc  = (wr_r == LAST_IDX) ? '0 : wr_r + 1'b1;
  assign rd_inc  = (rd_r == LAST_IDX) ? '0 : rd_r + 1'b1;

  always_comb begin
    zero_cnt_nxt = zero_cnt_r;
    mem_cnt_nxt  = mem_cnt_r;
    wr_nxt       = wr_r;
    rd_nxt       = rd_r;
    pop_bit      = 1'b0;
    if (ctl.prefill) begin
      zero_cnt_nxt = prefill_len;
      mem_cnt_nxt  = '0;
      wr_nxt       = rd_r;
    end else if (ctl.step) begin
      if (push_en) begin
        wr_nxt = wr_inc;
      end
      if (zero_cnt_r != '0) begin
        zero_cnt_nxt = zero_cnt_r - 1'b1;
        mem_cnt_nxt  = mem_cnt_r + AW'(push_en);
      end else if (mem_cnt_r == '0) begin
        // pushed bit passes straight through
        pop_bit = ctl.push_bit;
        rd_nxt  = rd_inc;
      end else begin
        pop_bit     = head_r;
        rd_nxt      = rd_inc;
        mem_cnt_nxt = mem_cnt_r + AW'(push_en) - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_cnt_r <= AW'(rtxs_pkg::RST_FILL);
      mem_cnt_r  <= '0;
      wr_r       <= '0;
      rd_r       <= '0;
    end else begin
      zero_cnt_r <= zero_cnt_nxt;
      mem_cnt_r  <= mem_cnt_nxt;
      wr_r       <= wr_nxt;
      rd_r       <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en && !ctl.prefill) begin
      mem[wr_r] <= ctl.push_bit;
    end
  end

  // head of the line, with write forwarding
  always_ff @(posedge clk) begin
    if (push_en && !ctl.prefill && (wr_r == rd_nxt)) begin
      head_r <= ctl.push_bit;
    end else begin
      head_r <= mem[rd_nxt];
    end
  end

endmodule

/* hdl/rx_tx_switch_sequencer.sv */
// rx/tx switch sequencer
// in_ channel: one item per transfer, in_tuser selects a timer tick (0) or a
// vox level sample (1). each tick produces exactly one out_ transfer, a vox
// sample produces none and only reloads the vox hold timer, on a vox hit.
// cfg_ port: write-only registers; the user writes them only while the block
// is idle, which the block itself does not enforce. a tick is registered at
// the input, then stepped; sequencer state and the out_ register load together.
// throughput: one item per cycle unless out_ stalls; the input and output
// registers let a new item enter while a finished result still waits on out_.
// the vox level scaling uses a gain multiplier per level before the input
// register and a reciprocal multiply per level for the divide by 100 after it.
// the key delay line is a one-bit memory of DELAY_DEPTH entries, read ahead
// into a head register; prefilled zeros are kept as a count, no clearing pass.
// reset: all timers zero, phase idle receive, registers at their defaults,
// delay line prefilled with 12 zeros; the input register starts empty.
// when out_tready is low the result holds and input transfers stop as soon
// as the output register is full and the input register holds a tick.
module rx_tx_switch_sequencer #(
  parameter int DELAY_DEPTH = 1024,
  parameter int BEEP_TICKS  = 40
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // key_down, key_ptt, tune_request, ptt_request, tx_ack, voice_level[7:0],
  // antivox_level[7:0], zero fill
  input  logic [23:0] in_tdata,
  // req_type
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // gate_valid, gate_index[1:0], gate_key, sidetone_on, tx_wanted, beep_on,
  // phase[2:0], zero fill
  output logic [15:0] out_tdata
);

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int LW = (AW > 10) ? AW : 10;
  localparam logic [LW-1:0] FILL_MAX = LW'(DELAY_DEPTH - 1);
  localparam logic [7:0]    BEEP_LEN = 8'(BEEP_TICKS);

  // configuration
  logic [7:0] pre_tx_r, rx_to_tx_r, tx_to_rx_r, mode_r;
  logic [9:0] breakin_hold_r, vox_hold_r;
  logic [6:0] vox_gain_r, avox_gain_r;

  // input register
  logic        s0_v_r;
  logic        s0_vox_r;
  logic [4:0]  s0_bits_r;
  logic [14:0] s0_vp_r, s0_ap_r;
  logic        s0_go;

  // sequencer state
  logic [2:0] phase_r, phase_nxt;
  logic [7:0] ptimer_r, ptimer_nxt;
  logic [9:0] breakin_r, breakin_nxt;
  logic [9:0] vox_r, vox_nxt;
  logic       beep_r, beep_nxt;

  // output register
  logic        out_v_r;
  logic [15:0] out_data_r, out_data_nxt;

  // delay line
  rtxs_pkg::dly_ctl_t dly_ctl;
  logic [AW-1:0]      fill_len;
  logic               dly_bit;
  logic               prefill;
  logic [8:0]         fill_sum;
  logic [LW-1:0]      fill_raw;

  // tick locals
  logic       key, kptt, tune, ptt, ack, cw;
  logic [9:0] bi_load, bi_dec, vox_dec;
  logic [1:0] side_gate;
  logic       side;
  logic       txreq;
  logic       tx_of_ph, tx_of_nxt;
  logic       gvalid, gkey;
  logic [1:0] gidx;
  logic [7:0] ptimer_dec;

  // vox compare
  logic [27:0] vq, aq;
  logic [9:0]  vlev, alev;
  logic        vox_hit;

  // -------------------------------------------------------------- config
  always_comb begin
    prefill  = 1'b0;
    fill_sum = {1'b0, pre_tx_r} + {1'b0, rx_to_tx_r};
    if (cfg_we) begin
      case (cfg_index)
        rtxs_pkg::REG_PRE_TX: begin
          prefill  = cfg_wdata[7:0] != pre_tx_r;
          fill_sum = {1'b0, cfg_wdata[7:0]} + {1'b0, rx_to_tx_r};
        end
        rtxs_pkg::REG_RX_TO_TX: begin
          prefill  = cfg_wdata[7:0] != rx_to_tx_r;
          fill_sum = {1'b0, pre_tx_r} + {1'b0, cfg_wdata[7:0]};
        end
        rtxs_pkg::REG_TX_TO_RX: begin
          prefill = cfg_wdata[7:0] != tx_to_rx_r;
        end
        default: begin
          prefill = 1'b0;
        end
      endcase
    end
    fill_raw = LW'({fill_sum, 1'b0});
    fill_len = (fill_raw > FILL_MAX) ? AW'(FILL_MAX) : AW'(fill_raw);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_tx_r       <= rtxs_pkg::PRE_TX_RST;
      rx_to_tx_r     <= rtxs_pkg::RX_TO_TX_RST;
      tx_to_rx_r     <= rtxs_pkg::TX_TO_RX_RST;
      breakin_hold_r <= rtxs_pkg::BREAKIN_RST;
      vox_hold_r     <= rtxs_pkg::VOX_HOLD_RST;
      vox_gain_r     <= '0;
      avox_gain_r    <= '0;
      mode_r         <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rtxs_pkg::REG_PRE_TX:    pre_tx_r       <= cfg_wdata[7:0];
        rtxs_pkg::REG_RX_TO_TX:  rx_to_tx_r     <= cfg_wdata[7:0];
        rtxs_pkg::REG_TX_TO_RX:  tx_to_rx_r     <= cfg_wdata[7:0];
        rtxs_pkg::REG_BREAKIN:   breakin_hold_r <= cfg_wdata;
        rtxs_pkg::REG_VOX_HOLD:  vox_hold_r     <= cfg_wdata;
        rtxs_pkg::REG_VOX_GAIN:  vox_gain_r     <= cfg_wdata[6:0];
        rtxs_pkg::REG_AVOX_GAIN: avox_gain_r    <= cfg_wdata[6:0];
        rtxs_pkg::REG_MODE:      mode_r         <= cfg_wdata[7:0];
        default:                 mode_r         <= mode_r;
      endcase
    end
  end

  // ------------------------------------------------------- input register
  assign s0_go     = s0_v_r & (s0_vox_r | ~out_v_r | out_tready);
  assign in_tready = ~s0_v_r | s0_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (in_tready) begin
      s0_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s0_vox_r  <= in_tuser;
      s0_bits_r <= in_tdata[4:0];
      s0_vp_r   <= {7'b0, in_tdata[12:5]} * {8'b0, vox_gain_r};
      s0_ap_r   <= {7'b0, in_tdata[20:13]} * {8'b0, avox_gain_r};
    end
  end

  // ------------------------------------------------------------ vox level
  assign vq      = {13'b0, s0_vp_r} * {15'b0, rtxs_pkg::DIV100_MUL};
  assign aq      = {13'b0, s0_ap_r} * {15'b0, rtxs_pkg::DIV100_MUL};
  assign vlev    = 10'(vq >> rtxs_pkg::DIV100_SHIFT);
  assign alev    = 10'(aq >> rtxs_pkg::DIV100_SHIFT);
  assign vox_hit = vlev >= (alev + rtxs_pkg::VOX_MARGIN);

  // ------------------------------------------------------------ tick step
  assign key  = s0_bits_r[0];
  assign kptt = s0_bits_r[1];
  assign tune = s0_bits_r[2];
  assign ptt  = s0_bits_r[3];
  assign ack  = s0_bits_r[4];
  assign cw   = mode_r[rtxs_pkg::MODE_CW];

  always_comb begin
    bi_load = ((key | kptt) & mode_r[rtxs_pkg::MODE_BREAKIN] & cw) ? breakin_hold_r
                                                                  : breakin_r;
    bi_dec  = (bi_load != '0) ? bi_load - 1'b1 : bi_load;
    vox_dec = (vox_r != '0) ? vox_r - 1'b1 : vox_r;

    case (phase_r)
      rtxs_pkg::PH_RX:              side_gate = rtxs_pkg::GATE_RX;
      rtxs_pkg::PH_TX,
      rtxs_pkg::PH_BEEP:            side_gate = key ? rtxs_pkg::GATE_TX_DOWN
                                                    : rtxs_pkg::GATE_TX_UP;
      default:                      side_gate = rtxs_pkg::GATE_TRANS;
    endcase
    side = mode_r[rtxs_pkg::MODE_SIDE + 32'(side_gate)] | key;

    tx_of_ph = (phase_r inside {[rtxs_pkg::PH_TX_ACK : rtxs_pkg::PH_TX_TO_RX]});

    if (tune | ptt) begin
      txreq = 1'b1;
    end else if (cw) begin
      txreq = bi_dec != '0;
    end else begin
      txreq = mode_r[rtxs_pkg::MODE_VOX] & (vox_dec != '0);
    end

    dly_ctl.step     = s0_go & ~s0_vox_r;
    dly_ctl.push_bit = cw & ((bi_dec != '0) | tx_of_ph) & key;
    dly_ctl.prefill  = prefill;

    ptimer_dec = ptimer_r - 1'b1;
    phase_nxt  = phase_r;
    ptimer_nxt = ptimer_r;
    beep_nxt   = beep_r;
    gvalid     = 1'b1;
    gidx       = rtxs_pkg::GATE_RX;
    gkey       = 1'b0;

    case (phase_r)
      rtxs_pkg::PH_RX: begin
        if (txreq) begin
          ptimer_nxt = pre_tx_r;
          phase_nxt  = (pre_tx_r == '0) ? rtxs_pkg::PH_TX_ACK : rtxs_pkg::PH_PRE_TX;
        end
      end
      rtxs_pkg::PH_PRE_TX: begin
        gidx       = rtxs_pkg::GATE_TRANS;
        ptimer_nxt = ptimer_dec;
        if (ptimer_dec == '0) phase_nxt = rtxs_pkg::PH_TX_ACK;
      end
      rtxs_pkg::PH_TX_ACK: begin
        gvalid = 1'b0;
        if (ack) begin
          ptimer_nxt = rx_to_tx_r;
          phase_nxt  = (rx_to_tx_r == '0) ? rtxs_pkg::PH_TX : rtxs_pkg::PH_RELAY;
        end
      end
      rtxs_pkg::PH_RELAY: begin
        gidx       = rtxs_pkg::GATE_TRANS;
        gkey       = key;
        ptimer_nxt = ptimer_dec;
        if (ptimer_dec == '0) phase_nxt = rtxs_pkg::PH_TX;
      end
      rtxs_pkg::PH_TX: begin
        gidx = dly_bit ? rtxs_pkg::GATE_TX_DOWN : rtxs_pkg::GATE_TX_UP;
        gkey = key;
        if (!txreq) begin
          if (mode_r[rtxs_pkg::MODE_ROGER]) begin
            ptimer_nxt = BEEP_LEN;
            beep_nxt   = 1'b1;
            phase_nxt  = rtxs_pkg::PH_BEEP;
          end else begin
            ptimer_nxt = tx_to_rx_r;
            phase_nxt  = (tx_to_rx_r == '0) ? rtxs_pkg::PH_RX_ACK
                                            : rtxs_pkg::PH_TX_TO_RX;
          end
        end
      end
      rtxs_pkg::PH_BEEP: begin
        gidx       = dly_bit ? rtxs_pkg::GATE_TX_DOWN : rtxs_pkg::GATE_TX_UP;
        ptimer_nxt = ptimer_dec;
        if (ptimer_dec == '0) begin
          beep_nxt   = 1'b0;
          ptimer_nxt = tx_to_rx_r;
          phase_nxt  = (tx_to_rx_r == '0) ? rtxs_pkg::PH_RX_ACK
                                          : rtxs_pkg::PH_TX_TO_RX;
        end
      end
      rtxs_pkg::PH_TX_TO_RX: begin
        gidx       = rtxs_pkg::GATE_TRANS;
        ptimer_nxt = ptimer_dec;
        if (ptimer_dec == '0) phase_nxt = rtxs_pkg::PH_RX_ACK;
      end
      default: begin
        gidx = rtxs_pkg::GATE_TRANS;
        if (!ack) phase_nxt = rtxs_pkg::PH_RX;
      end
    endcase

    tx_of_nxt = (phase_nxt inside {[rtxs_pkg::PH_TX_ACK : rtxs_pkg::PH_TX_TO_RX]});

    breakin_nxt = bi_dec;
    vox_nxt     = vox_dec;

    out_data_nxt = {6'b0, phase_nxt, beep_nxt, tx_of_nxt, side, gkey, gidx, gvalid};
  end

  rtxs_delay_line #(
    .DELAY_DEPTH (DELAY_DEPTH)
  ) u_delay (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (dly_ctl),
    .prefill_len (fill_len),
    .pop_bit     (dly_bit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= rtxs_pkg::PH_RX;
      ptimer_r  <= '0;
      breakin_r <= '0;
      vox_r     <= '0;
      beep_r    <= 1'b0;
    end else if (s0_go) begin
      if (s0_vox_r) begin
        if (vox_hit) vox_r <= vox_hold_r;
      end else begin
        phase_r   <= phase_nxt;
        ptimer_r  <= ptimer_nxt;
        breakin_r <= breakin_nxt;
        vox_r     <= vox_nxt;
        beep_r    <= beep_nxt;
      end
    end
  end

  // ------------------------------------------------------ output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s0_go && !s0_vox_r) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_go && !s0_vox_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

endmodule
